// ===== rtl/hbr_pkg.sv =====
// Package for the HTTP byte-range parser: parse state types, character
// constants and the types passed between the scan, resolve and check stages.
// No dependencies.
`default_nettype none

package hbr_pkg;

   localparam logic [2:0]  PREFIX_LEN  = 3'd6;
   localparam logic [47:0] PREFIX_TEXT = "bytes=";

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // value * 10 + d overflows 64 bits when value exceeds these
   localparam logic [63:0] OVF_LIMIT_LOW_DIGIT  = 64'd1844674407370955161;
   localparam logic [63:0] OVF_LIMIT_HIGH_DIGIT = 64'd1844674407370955160;

   typedef enum logic [1:0] {
      PH_WS,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } num_phase_type;

   typedef struct packed {
      num_phase_type phase;
      logic          negative;
      logic          overflow;
      logic [63:0]   value;
   } num_state_type;

   typedef struct packed {
      logic [2:0]    char_index;
      logic          prefix_bad;
      logic          terminated;
      num_state_type start_num;
      logic          dash_seen;
      logic          end_nonempty;
      num_state_type end_num;
   } parse_state_type;

   localparam num_state_type NUM_CLEAR = '{PH_WS, 1'b0, 1'b0, 64'd0};
   localparam parse_state_type PARSE_CLEAR =
      '{3'd0, 1'b0, 1'b0, NUM_CLEAR, 1'b0, 1'b0, NUM_CLEAR};

   // parse state as it stands after the last character of a header value
   typedef struct packed {
      logic          hdr_ok;
      logic          end_nonempty;
      num_state_type start_num;
      num_state_type end_num;
   } final_type;

   // numbers resolved to their strtoull values
   typedef struct packed {
      logic        hdr_ok;
      logic [63:0] start_val;
      logic [63:0] end_val;
      logic [63:0] size_m1;
   } resolved_type;

endpackage

`default_nettype wire

// ===== rtl/hbr_scan.sv =====
// Input word register and character scanner of the byte-range parser:
// prefix check, dash search and the two decimal number parsers.
// Depends on hbr_pkg.
`default_nettype none

module hbr_scan (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_ch,
   input  wire                req_last,
   output logic               fin_valid,
   input  wire                fin_ready,
   output hbr_pkg::final_type fin
);
   import hbr_pkg::*;

   logic            a_valid_ff, a_valid_in;
   logic [7:0]      a_ch_ff;
   logic            a_last_ff;
   logic            a_adv;
   parse_state_type st_ff, st_in, st_nxt;

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [7:0] prefix_char(logic [2:0] idx);
      logic [2:0] pos;
      pos = 3'd5 - idx;
      return PREFIX_TEXT[{pos, 3'b000} +: 8];
   endfunction

   function automatic num_state_type num_feed(num_state_type p, logic [7:0] c);
      num_state_type q;
      logic          digit;
      logic [3:0]    d;
      logic [63:0]   lim;
      q     = p;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d     = c[3:0];
      lim   = (d <= 4'd5) ? OVF_LIMIT_LOW_DIGIT : OVF_LIMIT_HIGH_DIGIT;
      if (p.phase != PH_DONE) begin
         if (p.phase == PH_WS && is_space(c)) begin
            q = p;
         end else if (p.phase == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
            q.negative = (c == CH_MINUS);
            q.phase    = PH_SIGN;
         end else if (!digit) begin
            q.phase = PH_DONE;
         end else begin
            q.phase = PH_DIGITS;
            if (p.overflow || p.value > lim) begin
               q.overflow = 1'b1;
            end else begin
               // multiply by ten as shift-add
               q.value = (p.value << 3) + (p.value << 1) + {60'd0, d};
            end
         end
      end
      return q;
   endfunction

   assign a_adv      = a_valid_ff && (!a_last_ff || fin_ready);
   assign req_ready  = !a_valid_ff || a_adv;
   assign a_valid_in = req_ready ? req_valid : a_valid_ff;

   always_comb begin
      st_nxt = st_ff;
      if (!st_ff.terminated) begin
         if (a_ch_ff == CH_NUL) begin
            st_nxt.terminated = 1'b1;
         end else if (st_ff.char_index < PREFIX_LEN) begin
            if (a_ch_ff != prefix_char(st_ff.char_index)) begin
               st_nxt.prefix_bad = 1'b1;
            end
            st_nxt.char_index = st_ff.char_index + 3'd1;
         end else begin
            st_nxt.start_num = num_feed(st_ff.start_num, a_ch_ff);
            if (st_ff.dash_seen) begin
               st_nxt.end_nonempty = 1'b1;
               st_nxt.end_num      = num_feed(st_ff.end_num, a_ch_ff);
            end else if (a_ch_ff == CH_MINUS) begin
               st_nxt.dash_seen = 1'b1;
            end
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      if (a_adv) begin
         // a finished header value starts the next one from scratch
         st_in = a_last_ff ? PARSE_CLEAR : st_nxt;
      end
   end

   assign fin_valid        = a_valid_ff && a_last_ff;
   assign fin.hdr_ok       = !st_nxt.prefix_bad && (st_nxt.char_index >= PREFIX_LEN)
                             && st_nxt.dash_seen;
   assign fin.end_nonempty = st_nxt.end_nonempty;
   assign fin.start_num    = st_nxt.start_num;
   assign fin.end_num      = st_nxt.end_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         st_ff      <= PARSE_CLEAR;
      end else begin
         a_valid_ff <= a_valid_in;
         st_ff      <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_ch_ff   <= req_ch;
         a_last_ff <= req_last;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hbr_resolve.sv =====
// Resolve stage of the byte-range parser: holds the final parse state and
// turns each number into its saturated or negated value. Depends on hbr_pkg.
`default_nettype none

module hbr_resolve (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [63:0]           resource_size,
   input  wire                   fin_valid,
   output logic                  fin_ready,
   input  wire hbr_pkg::final_type fin,
   output logic                  res_valid,
   input  wire                   res_ready,
   output hbr_pkg::resolved_type res
);
   import hbr_pkg::*;

   logic         b_valid_ff, b_valid_in;
   final_type    b_ff;
   logic         c_valid_ff, c_valid_in;
   resolved_type c_ff, c_in;
   logic         b_free, c_free;

   function automatic logic [63:0] num_result(num_state_type p);
      logic [63:0] r;
      if (p.overflow) begin
         r = '1;
      end else if (p.negative) begin
         r = 64'd0 - p.value;
      end else begin
         r = p.value;
      end
      return r;
   endfunction

   assign c_free     = !c_valid_ff || res_ready;
   assign b_free     = !b_valid_ff || c_free;
   assign fin_ready  = b_free;
   assign b_valid_in = b_free ? fin_valid : b_valid_ff;
   assign c_valid_in = c_free ? b_valid_ff : c_valid_ff;

   always_comb begin
      c_in.hdr_ok    = b_ff.hdr_ok;
      c_in.size_m1   = resource_size - 64'd1;
      c_in.start_val = num_result(b_ff.start_num);
      c_in.end_val   = b_ff.end_nonempty ? num_result(b_ff.end_num) : c_in.size_m1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free && fin_valid) begin
         b_ff <= fin;
      end
      if (c_free && b_valid_ff) begin
         c_ff <= c_in;
      end
   end

   assign res_valid = c_valid_ff;
   assign res       = c_ff;

endmodule

`default_nettype wire

// ===== rtl/hbr_check.sv =====
// Range check and result register of the byte-range parser: rejects an
// unsatisfiable range and clamps the end. Depends on hbr_pkg.
`default_nettype none

module hbr_check (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [63:0]           resource_size,
   input  wire                   res_valid,
   output logic                  res_ready,
   input  wire hbr_pkg::resolved_type res,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_ok,
   output logic [63:0]           rsp_range_start,
   output logic [63:0]           rsp_range_end
);
   import hbr_pkg::*;

   logic        d_valid_ff, d_valid_in;
   logic        ok_ff, ok_in;
   logic [63:0] start_ff, start_in;
   logic [63:0] end_ff, end_in;
   logic        d_free;

   assign d_free     = !d_valid_ff || rsp_ready;
   assign res_ready  = d_free;
   assign d_valid_in = d_free ? res_valid : d_valid_ff;

   always_comb begin
      ok_in    = res.hdr_ok && (res.start_val < resource_size)
                 && (res.start_val <= res.end_val);
      start_in = ok_in ? res.start_val : 64'd0;
      end_in   = res.size_m1;
      if (ok_in && (res.end_val < res.size_m1)) begin
         end_in = res.end_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_free && res_valid) begin
         ok_ff    <= ok_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_valid       = d_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_range_start = start_ff;
   assign rsp_range_end   = end_ff;

endmodule

`default_nettype wire

// ===== rtl/http_byte_range_parser.sv =====
// Each result passes the a (scan), b and c (resolve) and d (check) registers to rsp_valid.
// Throughput: one character word per cycle while req_ready is high; the state updates per word.
// Results queue through the resolve and result registers; req_ready drops only when all are full.
// Reset (synchronous): clears resource_size to 0, the parse state and every valid flag.
// Top level of the HTTP byte-range parser. Depends on hbr_pkg, hbr_scan,
// hbr_resolve and hbr_check.
`default_nettype none

module http_byte_range_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_ch,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_ok,
   output logic [63:0] rsp_range_start,
   output logic [63:0] rsp_range_end,
   input  wire         csr_write_en,
   input  wire  [63:0] csr_write_data
);
   import hbr_pkg::*;

   logic [63:0]  size_ff, size_in;
   logic         fin_valid, fin_ready;
   final_type    fin;
   logic         res_valid, res_ready;
   resolved_type res;

   assign size_in = csr_write_en ? csr_write_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 64'd0;
      end else begin
         size_ff <= size_in;
      end
   end

   hbr_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin       (fin)
   );

   hbr_resolve u_resolve (
      .clock         (clock),
      .reset         (reset),
      .resource_size (size_ff),
      .fin_valid     (fin_valid),
      .fin_ready     (fin_ready),
      .fin           (fin),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   hbr_check u_check (
      .clock           (clock),
      .reset           (reset),
      .resource_size   (size_ff),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end)
   );

endmodule

`default_nettype wire

// ===== rtl/hbr_checker.sv =====
// Port-level checks for the HTTP byte-range parser, bound to its top level.
// No dependencies beyond the top level's ports.
`default_nettype none

module hbr_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        rsp_ok,
   input wire [63:0] rsp_range_start,
   input wire [63:0] rsp_range_end
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_range_start) && $stable(rsp_range_end))
      else $error("stalled result word changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_range_start == 64'd0)
      else $error("rejected range with nonzero start");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_range_start <= rsp_range_end)
      else $error("accepted range with start past end");

endmodule

bind http_byte_range_parser hbr_checker u_hbr_checker (.*);

`default_nettype wire
